// ===== rtl/core/sfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // frame buffer geometry
    localparam int BUFFER_DEPTH = 16;
    localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
    // only entries 0..10 are ever inspected, later bytes are only counted
    localparam int BUF_USED     = 11;

    // idle counter saturation
    localparam int IDLE_W = 7;
    localparam logic [IDLE_W-1:0] IDLE_CAP = IDLE_W'(100);

    // frame lengths in bytes
    localparam logic [COUNT_W-1:0] LEN_STATUS = COUNT_W'(13);
    localparam logic [COUNT_W-1:0] LEN_QUERY  = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] LEN_MUTE   = COUNT_W'(9);

    // header and frame id bytes
    localparam logic [7:0] HDR_ESC    = 8'h1B;
    localparam logic [7:0] HDR_STX    = 8'h02;
    localparam logic [7:0] HDR_ETX    = 8'h03;
    localparam logic [7:0] ID_HI      = 8'h00;
    localparam logic [7:0] ID_STATUS  = 8'h01;
    localparam logic [7:0] ID_QUERY   = 8'h02;
    localparam logic [7:0] ID_MUTE    = 8'h03;
    localparam logic [7:0] REPLY_CMD  = 8'h12;
    localparam logic [7:0] REPLY_SUB  = 8'h01;
    localparam logic [7:0] FLAG_SET   = 8'h01;

    // query reply length
    localparam int REPLY_LEN = 9;
    localparam int BEAT_W    = $clog2(REPLY_LEN);
    localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(REPLY_LEN - 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_FLASH_HOLD   = 1'b1;

    // request kinds
    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic       reply;
        logic       los;
        logic [2:0] type_leds;
        logic [3:0] flash_leds;
        logic [3:0] log_leds;
        logic       buzzer;
        logic       link_ready;
    } sfr_desc_t;

    // byte of the status query reply at a given beat
    function automatic logic [7:0] reply_byte(input logic [BEAT_W-1:0] beat, input logic los);
        logic [7:0] b;
        case (beat)
            BEAT_W'(0): b = HDR_ESC;
            BEAT_W'(1): b = HDR_STX;
            BEAT_W'(2): b = ID_HI;
            BEAT_W'(3): b = REPLY_CMD;
            BEAT_W'(4): b = ID_HI;
            BEAT_W'(5): b = REPLY_SUB;
            BEAT_W'(6): b = {7'd0, los};
            BEAT_W'(7): b = HDR_ESC;
            BEAT_W'(8): b = HDR_ETX;
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfr_front
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        los_status,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wr_data,
    output sfr_desc_t        desc
);

    logic [7:0]         buf_reg [BUF_USED];
    logic [7:0]         buf_next [BUF_USED];
    logic [7:0]         buf_view [BUF_USED];
    logic [COUNT_W-1:0] count_reg, count_next, count_inc;
    logic [IDLE_W-1:0]  idle_reg, idle_next, idle_inc;
    logic [7:0]         ftmr_reg, ftmr_next, ftmr_inc;
    logic [2:0]         type_reg, type_next;
    logic [3:0]         flash_reg, flash_next;
    logic [3:0]         log_reg, log_next;
    logic               buzz_reg, buzz_next;
    logic               rdy_reg, rdy_next;
    logic [IDLE_W-1:0]  timeout_reg;
    logic [7:0]         hold_reg;
    logic               is_status, is_query, is_mute, done, bad_hdr;
    logic               reply_hit;
    req_t               req;

    assign req       = req_t'(req_type);
    assign count_inc = count_reg + COUNT_W'(1);
    assign idle_inc  = idle_reg + IDLE_W'(1);
    assign ftmr_inc  = ftmr_reg + 8'd1;

    // buffer as seen after the incoming byte is stored
    always_comb
    begin
        for (int i = 0; i < BUF_USED; i++)
        begin
            buf_view[i] = (count_reg == COUNT_W'(i)) ? rx_byte : buf_reg[i];
        end
    end

    // frame classification on the updated buffer
    assign is_status = (buf_view[2] == ID_HI) && (buf_view[3] == ID_STATUS)
                       && (count_inc == LEN_STATUS);
    assign is_query  = (buf_view[2] == ID_HI) && (buf_view[3] == ID_QUERY)
                       && (count_inc == LEN_QUERY);
    assign is_mute   = (buf_view[2] == ID_HI) && (buf_view[3] == ID_MUTE)
                       && (count_inc == LEN_MUTE);
    assign done      = is_status || is_query || is_mute;
    assign bad_hdr   = (buf_view[0] != HDR_ESC) && (buf_view[1] != HDR_STX);

    // next state for one accepted transaction
    always_comb
    begin
        buf_next   = buf_reg;
        count_next = count_reg;
        idle_next  = idle_reg;
        ftmr_next  = ftmr_reg;
        type_next  = type_reg;
        flash_next = flash_reg;
        log_next   = log_reg;
        buzz_next  = buzz_reg;
        rdy_next   = rdy_reg;
        reply_hit  = 1'b0;
        if (accept)
        begin
            case (req)
                REQ_BYTE:
                begin
                    if (count_reg < COUNT_W'(BUFFER_DEPTH))
                    begin
                        if (done)
                        begin
                            // completed frame clears the used part of the buffer
                            for (int i = 0; i < BUF_USED; i++)
                            begin
                                buf_next[i] = (COUNT_W'(i) <= count_reg) ? 8'd0 : buf_view[i];
                            end
                            count_next = '0;
                            idle_next  = '0;
                        end
                        else
                        begin
                            buf_next   = buf_view;
                            count_next = count_inc;
                            if (bad_hdr)
                            begin
                                count_next = '0;
                                idle_next  = '0;
                            end
                        end
                        if (is_status)
                        begin
                            if (buf_view[6] == 8'd0)
                            begin
                                type_next = 3'b001;
                            end
                            else if (buf_view[6] == 8'd1)
                            begin
                                type_next = 3'b010;
                            end
                            else if (buf_view[6] == 8'd2)
                            begin
                                type_next = 3'b100;
                            end
                            for (int i = 0; i < 4; i++)
                            begin
                                if (buf_view[7 + i] == FLAG_SET)
                                begin
                                    flash_next[i] = 1'b1;
                                    log_next[i]   = 1'b1;
                                    ftmr_next     = 8'd0;
                                end
                            end
                        end
                        if (is_query)
                        begin
                            rdy_next  = 1'b1;
                            reply_hit = 1'b1;
                        end
                        if (is_mute && (buf_view[6] == 8'd0))
                        begin
                            buzz_next = 1'b1;
                        end
                    end
                end
                REQ_TICK:
                begin
                    ftmr_next = ftmr_inc;
                    if (ftmr_inc == hold_reg)
                    begin
                        flash_next = '0;
                    end
                    if (idle_inc >= timeout_reg)
                    begin
                        count_next = '0;
                        for (int i = 0; i < BUF_USED; i++)
                        begin
                            buf_next[i] = 8'd0;
                        end
                    end
                    idle_next = (idle_inc >= IDLE_CAP) ? IDLE_CAP : idle_inc;
                end
                REQ_CLEAR:
                begin
                    flash_next = '0;
                    log_next   = '0;
                    buzz_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // indicators after this transaction travel with it
    assign desc.reply      = reply_hit;
    assign desc.los        = los_status;
    assign desc.type_leds  = type_next;
    assign desc.flash_leds = flash_next;
    assign desc.log_leds   = log_next;
    assign desc.buzzer     = buzz_next;
    assign desc.link_ready = rdy_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUF_USED; i++)
            begin
                buf_reg[i] <= 8'd0;
            end
            count_reg <= '0;
            idle_reg  <= IDLE_CAP;
            ftmr_reg  <= 8'd0;
            type_reg  <= 3'd0;
            flash_reg <= 4'd0;
            log_reg   <= 4'd0;
            buzz_reg  <= 1'b0;
            rdy_reg   <= 1'b0;
        end
        else
        begin
            buf_reg   <= buf_next;
            count_reg <= count_next;
            idle_reg  <= idle_next;
            ftmr_reg  <= ftmr_next;
            type_reg  <= type_next;
            flash_reg <= flash_next;
            log_reg   <= log_next;
            buzz_reg  <= buzz_next;
            rdy_reg   <= rdy_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= IDLE_W'(5);
            hold_reg    <= 8'd10;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_IDLE_TIMEOUT: timeout_reg <= cfg_wr_data[IDLE_W-1:0];
                CFG_FLASH_HOLD:   hold_reg    <= cfg_wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // counters stay in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(BUFFER_DEPTH))
        else $error("byte count beyond buffer depth");

    a_idle_range: assert property (@(posedge clk) disable iff (!rst_n)
        idle_reg <= IDLE_CAP)
        else $error("idle counter above saturation");

endmodule

`default_nettype wire

// ===== rtl/core/sfr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfr_queue
    import sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire sfr_desc_t  push_desc,
    output logic            full,
    output logic            head_valid,
    output sfr_desc_t       head_desc,
    input  wire logic       pop
);

    sfr_desc_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_desc  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // front never writes into a full queue, back never pops an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !head_valid))
        else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// ===== rtl/core/sfr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfr_back
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire sfr_desc_t   head_desc,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic              out_valid_reg, out_valid_next;
    logic [23:0]       data_reg;
    logic              user_reg, last_reg;
    logic              fire, beat_last;
    logic [7:0]        tx_byte;

    assign fire      = head_valid && (!out_valid_reg || m_axis_tready);
    assign beat_last = !head_desc.reply || (beat_reg == BEAT_LAST);
    assign pop       = fire && beat_last;
    assign tx_byte   = head_desc.reply ? reply_byte(beat_reg, head_desc.los) : 8'd0;

    // beat counter and output valid
    always_comb
    begin
        beat_next = beat_reg;
        if (fire)
        begin
            beat_next = beat_last ? '0 : beat_reg + BEAT_W'(1);
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= {3'd0, head_desc.link_ready, head_desc.buzzer, head_desc.log_leds,
                         head_desc.flash_leds, head_desc.type_leds, tx_byte};
            user_reg <= head_desc.reply;
            last_reg <= beat_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

    // a result without reply byte is always the only one of its transaction
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("non-reply result without last");

    // reply beats only advance while a reply is at the head
    a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_reg != '0) |-> (head_valid && head_desc.reply))
        else $error("reply beat counter running without a reply");

endmodule

`default_nettype wire

// ===== rtl/core/status_frame_receiver.sv =====
// path: with the queue empty and the output free, an accepted input transaction is written
//   to the queue and then to the output register, from which the result is on the master side
// throughput: one input transaction per cycle while the queue is not full; a status query
//   holds the output for its nine reply beats, the four-entry queue takes up to three more
//   transactions behind it, after that input stalls until the last reply beat leaves
// reset: rst_n clears the frame buffer, byte count, flash timer, indicators and queue at once,
//   sets the idle counter to 100, loads idle timeout 5 and flash hold 10 ticks; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module status_frame_receiver
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // rx_byte [7:0], los_status [8], zero [15:9]
    input  wire logic [1:0]  s_axis_tuser,   // req_type [1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // tx_byte [7:0], type_leds [10:8],
                                             // flash_leds [14:11], log_leds [18:15],
                                             // buzzer_out [19], link_ready [20], zero [23:21]
    output logic             m_axis_tuser,   // tx_valid
    output logic             m_axis_tlast,   // last
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wr_data
);

    sfr_desc_t front_desc, head_desc;
    logic      in_accept, q_full, head_valid, pop;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // front: frame assembly and indicator state
    sfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .req_type    (s_axis_tuser),
        .rx_byte     (s_axis_tdata[7:0]),
        .los_status  (s_axis_tdata[8]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .desc        (front_desc)
    );

    // queue of classified transactions
    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_desc  (front_desc),
        .full       (q_full),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop)
    );

    // back: result expansion and output register
    sfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_desc     (head_desc),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
